// ===== sv/bre_pkg.sv =====
// Package for the balancing-robot Euler step core.
// Holds register indexes, fixed-point constants and arithmetic helpers.
// No dependencies.
`default_nettype none

package bre_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int SUM_W     = 72;
    localparam int NUM_STATE = 7;
    localparam int NUM_TERMS = 7;

    localparam logic [REG_IDX_W-1:0] REG_STEP_YAWDAMP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_YAW_DRIVE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WHEEL_LINEAR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WHEEL_TRIG     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WHEEL_SQ_DRIVE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TILT_LINEAR    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TILT_TRIG      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TILT_SQ_DRIVE  = 3'd7;

    localparam logic signed [63:0] TURN_PER_RAD = 64'sd683565276;
    localparam logic [32:0]        HALF_PI_Q32  = 33'd6746518852;
    localparam logic [30:0]        Q30_ONE      = 31'h4000_0000;
    localparam logic [29:0]        HALF_TURN_OCT = 30'h2000_0000;

    // exact reciprocal multipliers for 31-bit numerators
    localparam int unsigned SH72 = 38;
    localparam int unsigned SH42 = 37;
    localparam int unsigned SH20 = 36;
    localparam int unsigned SH6  = 34;
    localparam int unsigned SH90 = 38;
    localparam int unsigned SH56 = 37;
    localparam int unsigned SH30 = 36;
    localparam int unsigned SH12 = 35;
    localparam logic [31:0] M72 = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
    localparam logic [31:0] M42 = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
    localparam logic [31:0] M20 = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
    localparam logic [31:0] M6  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
    localparam logic [31:0] M90 = 32'(((64'd1 << 38) + 64'd89) / 64'd90);
    localparam logic [31:0] M56 = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
    localparam logic [31:0] M30 = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
    localparam logic [31:0] M12 = 32'(((64'd1 << 35) + 64'd11) / 64'd12);

    localparam int TRIG_LAT = 12;
    localparam int ST_TRIG  = TRIG_LAT + 1;
    localparam int ST_CROSS = TRIG_LAT + 2;
    localparam int ST_PROD  = TRIG_LAT + 3;
    localparam int ST_ADD1  = TRIG_LAT + 4;
    localparam int ST_ADD2  = TRIG_LAT + 5;
    localparam int ST_ADD3  = TRIG_LAT + 6;
    localparam int ST_OUT   = TRIG_LAT + 7;

    typedef struct packed {
        logic [NUM_STATE-1:0][31:0] x;
        logic signed [31:0] ds;
        logic signed [31:0] dd;
        logic signed [31:0] m66;
        logic signed [31:0] m44;
        logic signed [31:0] m46;
        logic signed [31:0] sf;
        logic signed [31:0] q;
        logic signed [31:0] y;
        logic signed [31:0] xc;
    } carry_t;

    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        smul = 64'(a) * 64'(b);
    endfunction

    function automatic logic signed [SUM_W-1:0] round_shr(input logic signed [SUM_W-1:0] v,
                                                          input int unsigned n);
        round_shr = (v + (SUM_W'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic clipped(input logic signed [SUM_W-1:0] v);
        clipped = (v > SUM_W'(64'sd2147483647)) || (v < -SUM_W'(64'sd2147483648));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(64'sd2147483647)) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -SUM_W'(64'sd2147483648)) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic [30:0] mulhi30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] p;
        p = 61'(a) * 61'(b);
        mulhi30 = p[60:30];
    endfunction

    function automatic logic [30:0] mdiv(input logic [30:0] v, input logic [31:0] m,
                                         input int unsigned sh);
        logic [62:0] p;
        p = 63'(v) * 63'(m);
        mdiv = 31'(p >> sh);
    endfunction

endpackage

`default_nettype wire

// ===== sv/bre_trig.sv =====
// Pipelined sine and cosine of a Q-format angle, Q30 results, fixed latency.
// Depends on bre_pkg for constants and the reciprocal and product helpers.
`default_nettype none

module bre_trig
    import bre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               adv,
    input  wire logic signed [31:0] angle,
    output logic signed [31:0]      sin_out,
    output logic signed [31:0]      cos_out
);

    logic signed [63:0] prod_reg;
    logic [2:0]         oct_reg [1:10];
    logic [29:0]        th_reg  [1:9];
    logic [29:0]        p2_reg  [2:9];
    logic [30:0]        sp_reg  [3:9];
    logic [30:0]        cp_reg  [3:9];
    logic [30:0]        sv_reg;
    logic [30:0]        cv_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    logic [31:0]        phase;
    logic [29:0]        red;
    logic [62:0]        th_prod;
    logic [59:0]        p2_prod;
    logic [30:0]        sp_next [3:9];
    logic [30:0]        cp_next [3:9];
    logic signed [31:0] sv_ext;
    logic signed [31:0] cv_ext;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;

    always_comb begin
        phase   = prod_reg[FRAC_BITS +: 32];
        red     = phase[29] ? 30'(HALF_TURN_OCT - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
        th_prod = 63'(red) * 63'(HALF_PI_Q32);
        p2_prod = 60'(th_reg[1]) * 60'(th_reg[1]);

        sp_next[3] = Q30_ONE - mdiv({1'b0, p2_reg[2]}, M72, SH72);
        cp_next[3] = Q30_ONE - mdiv({1'b0, p2_reg[2]}, M90, SH90);
        sp_next[4] = mulhi30(p2_reg[3], sp_reg[3]);
        cp_next[4] = mulhi30(p2_reg[3], cp_reg[3]);
        sp_next[5] = Q30_ONE - mdiv(sp_reg[4], M42, SH42);
        cp_next[5] = Q30_ONE - mdiv(cp_reg[4], M56, SH56);
        sp_next[6] = mulhi30(p2_reg[5], sp_reg[5]);
        cp_next[6] = mulhi30(p2_reg[5], cp_reg[5]);
        sp_next[7] = Q30_ONE - mdiv(sp_reg[6], M20, SH20);
        cp_next[7] = Q30_ONE - mdiv(cp_reg[6], M30, SH30);
        sp_next[8] = mulhi30(p2_reg[7], sp_reg[7]);
        cp_next[8] = mulhi30(p2_reg[7], cp_reg[7]);
        sp_next[9] = Q30_ONE - mdiv(sp_reg[8], M6, SH6);
        cp_next[9] = Q30_ONE - mdiv(cp_reg[8], M12, SH12);

        sv_ext = {1'b0, sv_reg};
        cv_ext = {1'b0, cv_reg};
        // swap on octants 1,2,5,6; negate sine in the lower half turn
        if (oct_reg[10][0] ^ oct_reg[10][1]) begin
            sin_next = cv_ext;
            cos_next = sv_ext;
        end else begin
            sin_next = sv_ext;
            cos_next = cv_ext;
        end
        if (oct_reg[10][2]) begin
            sin_next = -sin_next;
        end
        if (oct_reg[10][1] ^ oct_reg[10][2]) begin
            cos_next = -cos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg   <= 64'(angle) * TURN_PER_RAD;
            oct_reg[1] <= phase[31:29];
            th_reg[1]  <= th_prod[61:32];
            p2_reg[2]  <= p2_prod[59:30];
            for (int i = 2; i <= 10; i++) begin
                oct_reg[i] <= oct_reg[i-1];
            end
            for (int i = 2; i <= 9; i++) begin
                th_reg[i] <= th_reg[i-1];
            end
            for (int i = 3; i <= 9; i++) begin
                p2_reg[i] <= p2_reg[i-1];
                sp_reg[i] <= sp_next[i];
                cp_reg[i] <= cp_next[i];
            end
            sv_reg  <= mulhi30(th_reg[9], sp_reg[9]);
            cv_reg  <= Q30_ONE - (mulhi30(p2_reg[9], cp_reg[9]) >> 1);
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

`default_nettype wire

// ===== sv/balancing_robot_euler_step_core.sv =====
// Top level of the balancing-robot forward-Euler step core.
// Depends on bre_pkg and bre_trig.
//
// One state vector plus two drive inputs in, the next state out, all signed
// fixed point with FRAC_BITS fraction bits. The core is a 19-stage pipeline:
// it takes one item per clock while the output side does not stall. The depth
// is set by the sine/cosine unit (twelve stages: phase multiply, octant fold,
// squaring, Horner steps with one multiply per stage, then the octant swap and
// sign) followed by the trig and cross products, the coefficient multiplies, a
// three-level adder tree and the final round and saturate. A stall on the
// output holds the whole pipeline. Coefficient registers are written through
// the cfg_wr port and reset to zero; the user must write them only while no
// item is in flight, as the core itself does not enforce this.
`default_nettype none

module balancing_robot_euler_step_core
    import bre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [63:0]          cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [31:0]   s_wheel_travel_in,
    input  wire logic signed [31:0]   s_wheel_angle_in,
    input  wire logic signed [31:0]   s_tilt_angle_in,
    input  wire logic signed [31:0]   s_wheel_rate_in,
    input  wire logic signed [31:0]   s_tilt_rate_in,
    input  wire logic signed [31:0]   s_yaw_angle_in,
    input  wire logic signed [31:0]   s_yaw_rate_in,
    input  wire logic signed [31:0]   s_left_drive,
    input  wire logic signed [31:0]   s_right_drive,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [31:0]        m_wheel_travel_out,
    output logic signed [31:0]        m_wheel_angle_out,
    output logic signed [31:0]        m_tilt_angle_out,
    output logic signed [31:0]        m_wheel_rate_out,
    output logic signed [31:0]        m_tilt_rate_out,
    output logic signed [31:0]        m_yaw_angle_out,
    output logic signed [31:0]        m_yaw_rate_out,
    output logic                      m_saturated
);

    logic [63:0]              coef_reg [NUM_REGS];
    logic                     vld_reg  [1:ST_OUT];
    carry_t                   d_reg    [1:ST_CROSS];
    logic signed [63:0]       term_reg [NUM_STATE][NUM_TERMS];
    logic signed [SUM_W-1:0]  a_reg    [NUM_STATE][4];
    logic signed [SUM_W-1:0]  b_reg    [NUM_STATE][2];
    logic signed [SUM_W-1:0]  sum_reg  [NUM_STATE];
    logic signed [31:0]       out_reg  [NUM_STATE];
    logic                     sat_reg;

    logic                     adv;
    logic signed [31:0]       sin_w;
    logic signed [31:0]       cos_w;
    logic signed [31:0]       clo [NUM_REGS];
    logic signed [31:0]       chi [NUM_REGS];
    carry_t                   d_next [1:ST_CROSS];
    logic signed [31:0]       sc_next;
    logic signed [31:0]       xc_half;
    logic signed [63:0]       term_next [NUM_STATE][NUM_TERMS];
    logic signed [SUM_W-1:0]  rnd [NUM_STATE];
    logic signed [31:0]       out_next [NUM_STATE];
    logic                     sat_next;
    logic signed [31:0]       x [NUM_STATE];
    logic signed [31:0]       ts;

    assign adv     = !vld_reg[ST_OUT] || m_ready;
    assign s_ready = adv;

    bre_trig #(
        .FRAC_BITS(FRAC_BITS)
    ) u_trig (
        .aclk   (aclk),
        .adv    (adv),
        .angle  (s_tilt_angle_in),
        .sin_out(sin_w),
        .cos_out(cos_w)
    );

    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            clo[i] = coef_reg[i][31:0];
            chi[i] = coef_reg[i][63:32];
        end

        d_next[1]      = '0;
        d_next[1].x[0] = s_wheel_travel_in;
        d_next[1].x[1] = s_wheel_angle_in;
        d_next[1].x[2] = s_tilt_angle_in;
        d_next[1].x[3] = s_wheel_rate_in;
        d_next[1].x[4] = s_tilt_rate_in;
        d_next[1].x[5] = s_yaw_angle_in;
        d_next[1].x[6] = s_yaw_rate_in;
        d_next[1].ds   = sat32(SUM_W'(s_left_drive) + SUM_W'(s_right_drive));
        d_next[1].dd   = sat32(SUM_W'(s_right_drive) - SUM_W'(s_left_drive));
        d_next[1].m66  = sat32(round_shr(SUM_W'(smul(s_yaw_rate_in, s_yaw_rate_in)),
                                         FRAC_BITS));
        d_next[1].m44  = sat32(round_shr(SUM_W'(smul(s_tilt_rate_in, s_tilt_rate_in)),
                                         FRAC_BITS));
        d_next[1].m46  = sat32(round_shr(SUM_W'(smul(s_tilt_rate_in, s_yaw_rate_in)),
                                         FRAC_BITS));
        for (int i = 2; i <= ST_CROSS; i++) begin
            d_next[i] = d_reg[i-1];
        end

        // trig stage: sin*cos, scaled sine, tilt-rate squared times sine
        sc_next            = 32'(round_shr(SUM_W'(smul(sin_w, cos_w)), 30));
        d_next[ST_TRIG].y  = sc_next;
        d_next[ST_TRIG].sf = 32'(round_shr(SUM_W'(sin_w), 30 - FRAC_BITS));
        d_next[ST_TRIG].q  = sat32(round_shr(SUM_W'(smul(d_reg[TRIG_LAT].m44, sin_w)), 30));

        // cross stage: the y field holds sin*cos on entry
        xc_half             = sat32(round_shr(SUM_W'(smul(d_reg[ST_TRIG].m46,
                                                          d_reg[ST_TRIG].y)), 30));
        d_next[ST_CROSS].y  = sat32(round_shr(SUM_W'(smul(d_reg[ST_TRIG].m66,
                                                          d_reg[ST_TRIG].y)), 30));
        d_next[ST_CROSS].xc = sat32(SUM_W'(xc_half) <<< 1);

        for (int i = 0; i < NUM_STATE; i++) begin
            x[i] = d_reg[ST_CROSS].x[i];
        end
        ts = clo[REG_STEP_YAWDAMP];
        for (int o = 0; o < NUM_STATE; o++) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                term_next[o][t] = '0;
            end
            term_next[o][0] = 64'(x[o]) <<< FRAC_BITS;
        end
        term_next[0][1] = smul(ts, x[1]);
        term_next[1][1] = smul(ts, x[3]);
        term_next[2][1] = smul(ts, x[4]);
        term_next[5][1] = smul(ts, x[6]);
        term_next[3][1] = smul(clo[REG_WHEEL_LINEAR], x[3]);
        term_next[3][2] = smul(chi[REG_WHEEL_LINEAR], x[4]);
        term_next[3][3] = smul(clo[REG_WHEEL_TRIG], d_reg[ST_CROSS].y);
        term_next[3][4] = smul(chi[REG_WHEEL_TRIG], d_reg[ST_CROSS].sf);
        term_next[3][5] = smul(clo[REG_WHEEL_SQ_DRIVE], d_reg[ST_CROSS].q);
        term_next[3][6] = smul(chi[REG_WHEEL_SQ_DRIVE], d_reg[ST_CROSS].ds);
        term_next[4][1] = smul(clo[REG_TILT_LINEAR], x[3]);
        term_next[4][2] = smul(chi[REG_TILT_LINEAR], x[4]);
        term_next[4][3] = smul(clo[REG_TILT_TRIG], d_reg[ST_CROSS].y);
        term_next[4][4] = smul(chi[REG_TILT_TRIG], d_reg[ST_CROSS].sf);
        term_next[4][5] = smul(clo[REG_TILT_SQ_DRIVE], d_reg[ST_CROSS].q);
        term_next[4][6] = smul(chi[REG_TILT_SQ_DRIVE], d_reg[ST_CROSS].ds);
        term_next[6][1] = smul(chi[REG_STEP_YAWDAMP], x[6]);
        term_next[6][2] = smul(clo[REG_YAW_DRIVE], d_reg[ST_CROSS].dd);
        term_next[6][3] = smul(chi[REG_YAW_DRIVE], d_reg[ST_CROSS].xc);

        sat_next = 1'b0;
        for (int o = 0; o < NUM_STATE; o++) begin
            rnd[o]      = round_shr(sum_reg[o], FRAC_BITS);
            out_next[o] = sat32(rnd[o]);
            sat_next    = sat_next | clipped(rnd[o]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
            for (int i = 1; i <= ST_OUT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                coef_reg[cfg_wr_index] <= cfg_wr_data;
            end
            if (adv) begin
                vld_reg[1] <= s_valid;
                for (int i = 2; i <= ST_OUT; i++) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 1; i <= ST_CROSS; i++) begin
                d_reg[i] <= d_next[i];
            end
            for (int o = 0; o < NUM_STATE; o++) begin
                for (int t = 0; t < NUM_TERMS; t++) begin
                    term_reg[o][t] <= term_next[o][t];
                end
                a_reg[o][0] <= SUM_W'(term_reg[o][0]) + SUM_W'(term_reg[o][1]);
                a_reg[o][1] <= SUM_W'(term_reg[o][2]) + SUM_W'(term_reg[o][3]);
                a_reg[o][2] <= SUM_W'(term_reg[o][4]) + SUM_W'(term_reg[o][5]);
                a_reg[o][3] <= SUM_W'(term_reg[o][6]);
                b_reg[o][0] <= a_reg[o][0] + a_reg[o][1];
                b_reg[o][1] <= a_reg[o][2] + a_reg[o][3];
                sum_reg[o]  <= b_reg[o][0] + b_reg[o][1];
                out_reg[o]  <= out_next[o];
            end
            sat_reg <= sat_next;
        end
    end

    assign m_valid            = vld_reg[ST_OUT];
    assign m_wheel_travel_out = out_reg[0];
    assign m_wheel_angle_out  = out_reg[1];
    assign m_tilt_angle_out   = out_reg[2];
    assign m_wheel_rate_out   = out_reg[3];
    assign m_tilt_rate_out    = out_reg[4];
    assign m_yaw_angle_out    = out_reg[5];
    assign m_yaw_rate_out     = out_reg[6];
    assign m_saturated        = sat_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for balancing_robot_euler_step_core: random and directed state vectors,
// a built-in fixed-point predictor of the Euler step, and a streaming compare.
// Depends on bre_pkg and the core RTL.
`default_nettype none

module tb;
    import bre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x [7];
        logic signed [31:0] lf;
        logic signed [31:0] rt;
    } step_in_t;

    typedef struct {
        logic signed [31:0] x [7];
        logic               sat;
    } step_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_wr_index = '0;
    logic [63:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_x [7] = '{default: '0};
    logic signed [31:0] s_left_drive = '0, s_right_drive = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_x [7];
    logic m_saturated;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    balancing_robot_euler_step_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_wheel_travel_in(s_x[0]), .s_wheel_angle_in(s_x[1]), .s_tilt_angle_in(s_x[2]),
        .s_wheel_rate_in(s_x[3]), .s_tilt_rate_in(s_x[4]), .s_yaw_angle_in(s_x[5]),
        .s_yaw_rate_in(s_x[6]), .s_left_drive(s_left_drive), .s_right_drive(s_right_drive),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_wheel_travel_out(m_x[0]), .m_wheel_angle_out(m_x[1]), .m_tilt_angle_out(m_x[2]),
        .m_wheel_rate_out(m_x[3]), .m_tilt_rate_out(m_x[4]), .m_yaw_angle_out(m_x[5]),
        .m_yaw_rate_out(m_x[6]), .m_saturated(m_saturated)
    );

    localparam int FB = 16;
    localparam int WATCHDOG = 2000;

    logic [63:0] coef_regs [NUM_REGS];
    step_in_t   pending_steps [$];
    step_out_t  expected_states [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  stim_done = 1'b0;
    bit  quiet = 1'b0;
    int  src_gap = 0, snk_gap = 0;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_half_up(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint coef_of(int r, bit upper);
        logic [31:0] w;
        w = upper ? coef_regs[r][63:32] : coef_regs[r][31:0];
        return longint'($signed(w));
    endfunction

    function automatic longint qmul(longint a, longint b, int n);
        bit dummy;
        dummy = 1'b0;
        return clamp32(round_half_up(a * b, n), dummy);
    endfunction

    function automatic void sin_cos(longint ang, output longint sn, output longint cs);
        longint prod, th, p2, s, c, sv, cv;
        logic [63:0] pw;
        logic [31:0] ph;
        logic [2:0] oct;
        longint unsigned r;
        prod = ang * 64'sd683565276;
        pw = prod;
        ph = pw[FB+31:FB];
        oct = ph[31:29];
        r = 64'(ph[28:0]);
        if (oct[0]) r = 64'h2000_0000 - r;
        th = longint'((r * 64'd6746518852) >> 32);
        p2 = (th * th) >>> 30;
        s = 64'sd1 << 30;
        s = (64'sd1 << 30) - ((p2 * s) >>> 30) / 72;
        s = (64'sd1 << 30) - ((p2 * s) >>> 30) / 42;
        s = (64'sd1 << 30) - ((p2 * s) >>> 30) / 20;
        s = (64'sd1 << 30) - ((p2 * s) >>> 30) / 6;
        sv = (th * s) >>> 30;
        c = 64'sd1 << 30;
        c = (64'sd1 << 30) - ((p2 * c) >>> 30) / 90;
        c = (64'sd1 << 30) - ((p2 * c) >>> 30) / 56;
        c = (64'sd1 << 30) - ((p2 * c) >>> 30) / 30;
        c = (64'sd1 << 30) - ((p2 * c) >>> 30) / 12;
        cv = (64'sd1 << 30) - ((p2 * c) >>> 30) / 2;
        case (oct)
            3'd0: begin sn = sv;  cs = cv;  end
            3'd1: begin sn = cv;  cs = sv;  end
            3'd2: begin sn = cv;  cs = -sv; end
            3'd3: begin sn = sv;  cs = -cv; end
            3'd4: begin sn = -sv; cs = -cv; end
            3'd5: begin sn = -cv; cs = -sv; end
            3'd6: begin sn = -cv; cs = sv;  end
            default: begin sn = -sv; cs = cv; end
        endcase
    endfunction

    // exact sum of products split into integer and fraction parts, then rounded
    function automatic longint sum_round(longint terms [7], int cnt, inout bit hit);
        longint hi, lo;
        hi = 0;
        lo = 0;
        for (int i = 0; i < cnt; i++) begin
            hi += floor_shr(terms[i], FB);
            lo += terms[i] & ((64'sd1 << FB) - 1);
        end
        return clamp32(hi + ((lo + (64'sd1 << (FB - 1))) >>> FB), hit);
    endfunction

    function automatic step_out_t predict_next_state(step_in_t it);
        step_out_t o;
        longint x [7];
        longint t [7];
        longint s, c, sc, sf, y, q, xc, ds, dd, ts;
        bit hit, dummy;
        hit = 1'b0;
        dummy = 1'b0;
        for (int i = 0; i < 7; i++) x[i] = longint'(it.x[i]);
        ts = coef_of(REG_STEP_YAWDAMP, 0);
        sin_cos(x[2], s, c);
        sc = round_half_up(s * c, 30);
        sf = round_half_up(s, 30 - FB);
        y = qmul(qmul(x[6], x[6], FB), sc, 30);
        q = qmul(qmul(x[4], x[4], FB), s, 30);
        xc = clamp32(2 * qmul(qmul(x[4], x[6], FB), sc, 30), dummy);
        ds = clamp32(longint'(it.lf) + longint'(it.rt), dummy);
        dd = clamp32(longint'(it.rt) - longint'(it.lf), dummy);
        foreach (o.x[k]) o.x[k] = '0;
        for (int k = 0; k < 7; k++) begin
            int rate;
            if (k == 3 || k == 4 || k == 6) continue;
            rate = (k == 0) ? 1 : (k == 1) ? 3 : (k == 2) ? 4 : 6;
            t[0] = x[k] <<< FB;
            t[1] = ts * x[rate];
            o.x[k] = 32'(sum_round(t, 2, hit));
        end
        for (int k = 3; k <= 4; k++) begin
            int b;
            b = (k == 3) ? REG_WHEEL_LINEAR : REG_TILT_LINEAR;
            t[0] = x[k] <<< FB;
            t[1] = coef_of(b, 0) * x[3];
            t[2] = coef_of(b, 1) * x[4];
            t[3] = coef_of(b + 1, 0) * y;
            t[4] = coef_of(b + 1, 1) * sf;
            t[5] = coef_of(b + 2, 0) * q;
            t[6] = coef_of(b + 2, 1) * ds;
            o.x[k] = 32'(sum_round(t, 7, hit));
        end
        t[0] = x[6] <<< FB;
        t[1] = coef_of(REG_STEP_YAWDAMP, 1) * x[6];
        t[2] = coef_of(REG_YAW_DRIVE, 0) * dd;
        t[3] = coef_of(REG_YAW_DRIVE, 1) * xc;
        o.x[6] = 32'(sum_round(t, 4, hit));
        o.sat = hit;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    3: return 32'sh0001_0000;
                    default: return -32'sh0001_0000;
                endcase
            end
        endcase
    endfunction

    function automatic step_in_t rand_step(int mode);
        step_in_t it;
        for (int i = 0; i < 7; i++) it.x[i] = rand_word(mode == 4 ? $urandom_range(0, 3) : mode);
        it.lf = rand_word(mode == 4 ? $urandom_range(0, 3) : mode);
        it.rt = rand_word(mode == 4 ? $urandom_range(0, 3) : mode);
        return it;
    endfunction

    function automatic logic [63:0] rand_coef_pair(int mode);
        logic [31:0] a, b;
        a = rand_word(mode);
        b = rand_word(mode);
        return {b, a};
    endfunction

    task automatic write_coef(int idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx[REG_IDX_W-1:0];
        cfg_wr_data <= val;
        coef_regs[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_steps.size() != 0 || s_valid || expected_states.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_states.push_back(predict_next_state(pending_steps.pop_front()));
            end
            if (src_gap > 0) src_gap <= src_gap - 1;
            if (!s_valid || s_ready) begin
                if (src_gap == 0 && pending_steps.size() != 0) begin
                    step_in_t nx;
                    nx = pending_steps[0];
                    s_valid <= 1'b1;
                    for (int i = 0; i < 7; i++) s_x[i] <= nx.x[i];
                    s_left_drive <= nx.lf;
                    s_right_drive <= nx.rt;
                    if (!quiet && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer at %0t", $realtime);
                end else begin
                    step_out_t e;
                    bit bad;
                    e = expected_states.pop_front();
                    bad = (m_saturated !== e.sat);
                    for (int i = 0; i < 7; i++) if (m_x[i] !== e.x[i]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t: sat exp %0d got %0d", $realtime,
                                     e.sat, m_saturated);
                            for (int i = 0; i < 7; i++)
                                $display("  state[%0d] exp %0d got %0d", i, e.x[i], m_x[i]);
                        end
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                snk_gap <= $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !stim_done) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        step_in_t it;
        for (int i = 0; i < NUM_REGS; i++) coef_regs[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, extreme, then small random coefficients, each with extreme inputs and a tilt sweep
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                for (int r = 0; r < NUM_REGS; r++) write_coef(r, 64'h7FFF_FFFF_8000_0000);
            end
            if (p == 2) begin
                for (int r = 0; r < NUM_REGS; r++) write_coef(r, rand_coef_pair(1));
                write_coef(REG_STEP_YAWDAMP, {rand_word(1), 32'h0000_0148});
            end
            for (int k = 0; k < 8; k++) begin
                for (int i = 0; i < 7; i++) it.x[i] = (k[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                it.lf = k[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                it.rt = k[2] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                // tilt steps by pi/8 through octants 0 to 3 of a turn
                it.x[2] = 32'sh0000_6487 * k + 32'sh0000_3000;
                pending_steps.push_back(it);
            end
            drain();
        end

        // random phases under varied coefficient settings
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < NUM_REGS; r++) write_coef(r, rand_coef_pair(ph % 4));
            if (ph == 7) quiet = 1'b1;
            for (int n = 0; n < 100; n++) pending_steps.push_back(rand_step(ph % 2 ? 4 : 1));
            drain();
        end
        stim_done = 1'b1;
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // timeout on the draining itself
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (idle_cycles >= WATCHDOG) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
